// File: design/nied_pkg.sv
// Shared types, constants and helpers for the NEC IR edge decoder.
// No dependencies; every other design file imports this package.
package nied_pkg;

    // Field widths
    localparam int TIME_W    = 16;
    localparam int LEN_W     = 14;
    localparam int TOL_W     = 8;
    localparam int PROD_W    = LEN_W + TOL_W;
    localparam int WORD_W    = 16;
    localparam int BITCNT_W  = 6;
    localparam int STCODE_W  = 3;
    localparam int OUT_W     = 48;
    localparam int CFG_IDX_W = 3;

    // Frame layout
    localparam logic [BITCNT_W-1:0] BITS_PER_WORD = 6'd16;
    localparam logic [BITCNT_W-1:0] BITS_TOTAL    = 6'd32;

    // Interval queue between classifier and decoder
    localparam int FIFO_DEPTH = 4;

    // Configuration register indexes; lengths occupy indexes 0..5
    localparam int LEN_COUNT = 6;
    localparam logic [CFG_IDX_W-1:0] REG_AGC    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPACER = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BURST  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ONE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TOL    = 3'd6;

    // Register reset values, in index order
    localparam logic [LEN_W-1:0] RST_LEN [LEN_COUNT] =
        '{14'd9000, 14'd4500, 14'd2250, 14'd562, 14'd1687, 14'd562};
    localparam logic [TOL_W-1:0] RST_TOL = 8'd64;

    // Reported state codes
    localparam logic [STCODE_W-1:0] CODE_INVALID = 3'd0;
    localparam logic [STCODE_W-1:0] CODE_AGC     = 3'd1;
    localparam logic [STCODE_W-1:0] CODE_SPACER  = 3'd2;
    localparam logic [STCODE_W-1:0] CODE_REPEAT  = 3'd3;
    localparam logic [STCODE_W-1:0] CODE_CODE    = 3'd4;
    localparam logic [STCODE_W-1:0] CODE_DONE    = 3'd5;

    // Decoder state, one-hot
    typedef enum logic [5:0] {
        ST_INVALID = 6'b000001,
        ST_AGC     = 6'b000010,
        ST_SPACER  = 6'b000100,
        ST_REPEAT  = 6'b001000,
        ST_CODE    = 6'b010000,
        ST_DONE    = 6'b100000
    } t_state;

    // One classified edge as queued from front to back
    typedef struct packed {
        logic first;
        logic last;
        logic m_agc;
        logic m_spacer;
        logic m_repeat;
        logic m_burst;
        logic m_one;
        logic m_zero;
    } t_class;

    // Deviation bound: |a - c| * 256 <= c * tol  <=>  |a - c| <= (c * tol) >> 8
    function automatic logic [LEN_W-1:0] thr_of(input logic [LEN_W-1:0] len,
                                                 input logic [TOL_W-1:0] tol);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(len) * PROD_W'(tol);
        return prod[PROD_W-1:TOL_W];
    endfunction

    function automatic logic [STCODE_W-1:0] state_code(input t_state st);
        logic [STCODE_W-1:0] code;
        unique case (st)
            ST_INVALID: code = CODE_INVALID;
            ST_AGC:     code = CODE_AGC;
            ST_SPACER:  code = CODE_SPACER;
            ST_REPEAT:  code = CODE_REPEAT;
            ST_CODE:    code = CODE_CODE;
            ST_DONE:    code = CODE_DONE;
            default:    code = CODE_INVALID;
        endcase
        return code;
    endfunction

endpackage

// File: design/nied_fifo.sv
// Small register queue carrying classified edges from front to back.
// Depends on nied_pkg (t_class, FIFO_DEPTH).
module nied_fifo
    import nied_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_class i_data,
    output logic   o_full,
    input  logic   i_pop,
    output t_class o_data,
    output logic   o_empty
);
    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    t_class           r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rptr];

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("queue read while empty");

endmodule

// File: design/nied_front.sv
// Front end: configuration registers, interval computation and length matching.
// Depends on nied_pkg (widths, register indexes, thr_of, t_class).
module nied_front
    import nied_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // edge input
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [TIME_W-1:0]    i_time,
    input  logic                 i_first,
    input  logic                 i_last,
    // configuration writes
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [LEN_W-1:0]     i_cfg_wdata,
    // queue side
    input  logic                 i_full,
    output logic                 o_push,
    output t_class               o_class
);
    localparam int TB = TIME_W;

    logic [LEN_W-1:0]  r_len [LEN_COUNT];
    logic [TOL_W-1:0]  r_tol;
    logic [TIME_W-1:0] r_prev;

    logic [TB-1:0]        interval;
    logic [LEN_COUNT-1:0] match;

    // Configuration registers; out-of-range indexes fall through
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LEN_COUNT; i++) begin
                r_len[i] <= RST_LEN[i];
            end
            r_tol <= RST_TOL;
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_TOL) begin
                r_tol <= i_cfg_wdata[TOL_W-1:0];
            end else if (i_cfg_index < REG_TOL) begin
                r_len[i_cfg_index] <= i_cfg_wdata;
            end
        end
    end

    // Previous timestamp; ignored edges only occur before a window opener
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
        end else if (o_push) begin
            r_prev <= i_time;
        end
    end

    // Interval modulo 2^TB and tolerance match against each length
    assign interval = TB'(i_time) - TB'(r_prev);

    // Deviation bound per length is (len * tol) >> 8, taken from the live registers
    always_comb begin
        logic [TB-1:0] nom;
        logic [TB-1:0] dev;
        for (int i = 0; i < LEN_COUNT; i++) begin
            nom      = TB'(r_len[i]);
            dev      = (interval >= nom) ? interval - nom : nom - interval;
            match[i] = (dev <= TB'(thr_of(r_len[i], r_tol)));
        end
    end

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        o_class.first    = i_first;
        o_class.last     = i_last;
        o_class.m_agc    = match[REG_AGC];
        o_class.m_spacer = match[REG_SPACER];
        o_class.m_repeat = match[REG_REPEAT];
        o_class.m_burst  = match[REG_BURST];
        o_class.m_one    = match[REG_ONE];
        o_class.m_zero   = match[REG_ZERO];
    end

endmodule

// File: design/nied_back.sv
// Back end: NEC frame state machine, bit collection and result register.
// Depends on nied_pkg (t_state, t_class, frame constants, state_code).
module nied_back
    import nied_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    // queue side
    input  t_class           i_class,
    input  logic             i_empty,
    output logic             o_pop,
    // result stream
    output logic             o_valid,
    input  logic             i_ready,
    output logic [OUT_W-1:0] o_data
);
    t_state                r_state, n_state;
    logic [BITCNT_W-1:0]   r_bitpos, n_bitpos;
    logic [WORD_W-1:0]     r_addr, n_addr;
    logic [WORD_W-1:0]     r_cmd, n_cmd;
    logic                  r_phase, n_phase;
    logic                  r_finished, n_finished;
    logic                  r_out_valid;
    logic [OUT_W-1:0]      r_out_data;

    logic emit;
    logic fall_sp, fall_code, fall_inv, fall_done;

    assign o_pop   = !i_empty && (!r_out_valid || i_ready);
    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

    // Next-state logic, case entries fall through like the frame spec
    always_comb begin
        n_state    = r_state;
        n_bitpos   = r_bitpos;
        n_addr     = r_addr;
        n_cmd      = r_cmd;
        n_phase    = r_phase;
        n_finished = r_finished;
        emit       = 1'b0;
        fall_sp    = 1'b0;
        fall_code  = 1'b0;
        fall_inv   = 1'b0;
        fall_done  = 1'b0;
        if (o_pop) begin
            if (i_class.first) begin
                n_state    = ST_INVALID;
                n_bitpos   = '0;
                n_addr     = '0;
                n_cmd      = '0;
                n_phase    = 1'b0;
                n_finished = i_class.last;
                emit       = i_class.last;
            end else if (!r_finished) begin
                n_phase = ~r_phase;
                unique case (r_state)
                    ST_AGC: begin
                        if (i_class.m_spacer) begin
                            n_state = ST_SPACER;
                            n_phase = 1'b0;
                        end else if (i_class.m_repeat) begin
                            n_state = ST_REPEAT;
                        end else begin
                            fall_sp = 1'b1;
                        end
                    end
                    ST_SPACER:  fall_sp   = 1'b1;
                    ST_CODE:    fall_code = 1'b1;
                    ST_DONE:    fall_done = 1'b1;
                    ST_REPEAT:  ;
                    ST_INVALID: fall_inv  = 1'b1;
                    default:    fall_inv  = 1'b1;
                endcase
                // spacer: burst opens the data section
                if (fall_sp) begin
                    if (i_class.m_burst) begin
                        n_state  = ST_CODE;
                        n_bitpos = '0;
                        n_addr   = '0;
                        n_cmd    = '0;
                    end else begin
                        fall_code = 1'b1;
                    end
                end
                // code: even phase carries a bit space, odd phase a burst
                if (fall_code) begin
                    if (!n_phase) begin
                        if (i_class.m_one) begin
                            if (r_bitpos < BITS_PER_WORD) begin
                                n_addr   = r_addr | (WORD_W'(1) << r_bitpos[3:0]);
                                n_bitpos = r_bitpos + 1'b1;
                            end else if (r_bitpos < BITS_TOTAL) begin
                                n_cmd    = r_cmd | (WORD_W'(1) << r_bitpos[3:0]);
                                n_bitpos = r_bitpos + 1'b1;
                            end else begin
                                n_state = ST_DONE;
                            end
                        end else if (i_class.m_zero) begin
                            if (r_bitpos < BITS_TOTAL) begin
                                n_bitpos = r_bitpos + 1'b1;
                            end else begin
                                n_state = ST_DONE;
                            end
                        end else begin
                            fall_inv = 1'b1;
                        end
                    end else if (!i_class.m_burst) begin
                        fall_inv = 1'b1;
                    end
                end
                // invalid: a full frame still completes
                if (fall_inv) begin
                    if (r_bitpos < BITS_TOTAL) begin
                        n_state = ST_INVALID;
                    end else begin
                        fall_done = 1'b1;
                    end
                end
                // done ends the window here; otherwise an AGC length restarts
                if (fall_done) begin
                    n_state    = ST_DONE;
                    n_finished = 1'b1;
                    emit       = 1'b1;
                end else begin
                    if (i_class.m_agc) begin
                        n_state = ST_AGC;
                    end
                    if (i_class.last) begin
                        n_finished = 1'b1;
                        emit       = 1'b1;
                    end
                end
            end
        end
    end

    // Decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_INVALID;
            r_bitpos   <= '0;
            r_addr     <= '0;
            r_cmd      <= '0;
            r_phase    <= 1'b0;
            r_finished <= 1'b1;
        end else begin
            r_state    <= n_state;
            r_bitpos   <= n_bitpos;
            r_addr     <= n_addr;
            r_cmd      <= n_cmd;
            r_phase    <= n_phase;
            r_finished <= n_finished;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_data <= {(OUT_W - BITCNT_W - STCODE_W - 2 * WORD_W)'(0),
                           n_bitpos, state_code(n_state), n_cmd, n_addr};
        end
    end

    a_bitpos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bitpos <= BITS_TOTAL)
        else $error("bit count beyond frame length");

    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("decoder state not one-hot");

    a_emit_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> r_finished && r_out_valid)
        else $error("result issued while window stays open");

endmodule

// File: design/nec_ir_edge_decoder_core.sv
// NEC IR edge decoder, top level: edge classifier, interval queue, frame decoder.
// Depends on nied_pkg, nied_front, nied_fifo and nied_back.
//
// Usage:
//   The slave stream carries one IR edge timestamp (microseconds) per
//   transaction; tuser marks the first edge of a capture window, tlast the
//   last. The master stream carries one result per completed window:
//   address, command, final state code and bit count.
//   Each edge is timed against the previous one and matched against the
//   configured lengths in the cycle it is accepted, then queued (4 entries).
//   The frame decoder takes one queued edge per cycle while the result register
//   is empty or being taken, so one edge per cycle is then sustained. tvalid on
//   the master side is registered: the edge closing the window passes through
//   the queue and then the result register before the result can be taken.
//   Reset loads the default NEC timings, empties the queue and leaves the
//   decoder waiting for a window opener; edges before it are dropped.
//   When the master side stalls, the result register holds, the decoder
//   stops and tready drops once the queue has filled.
//   Configuration registers are written through i_cfg_*; write them only
//   while no window is in flight.
module nec_ir_edge_decoder_core
    import nied_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // edge stream
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [TIME_W-1:0]    i_s_axis_tdata,   // [15:0] edge_time
    input  logic                 i_s_axis_tuser,   // [0] first_edge
    input  logic                 i_s_axis_tlast,   // last_edge
    // result stream
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [OUT_W-1:0]     o_m_axis_tdata,   // [15:0] address, [31:16] command,
                                                   // [34:32] final_state,
                                                   // [40:35] bit_count, [47:41] zero
    // configuration
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [LEN_W-1:0]     i_cfg_wdata
);
    t_class push_class;
    t_class head_class;
    logic   push;
    logic   pop;
    logic   full;
    logic   empty;

    // Classifier
    nied_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_time      (i_s_axis_tdata),
        .i_first     (i_s_axis_tuser),
        .i_last      (i_s_axis_tlast),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_full      (full),
        .o_push      (push),
        .o_class     (push_class)
    );

    // Interval queue
    nied_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_class),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (head_class),
        .o_empty (empty)
    );

    // Frame decoder and result register
    nied_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_class (head_class),
        .i_empty (empty),
        .o_pop   (pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (o_m_axis_tdata)
    );

endmodule

// File: bench/nec_ir_edge_decoder_core_test.sv
// Self-checking testbench for nec_ir_edge_decoder_core: edge stream in, decoded frame out.
// Depends on nied_pkg and the design sources; carries its own behavioral decoder model.
`timescale 1ns / 100ps

module nec_ir_edge_decoder_core_test;
    import nied_pkg::*;

    localparam int CLK_PERIOD    = 8;
    localparam int RESET_CYCLES  = 4;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 2000000;

    // index past the register file, writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef enum int {WIN_FRAME, WIN_REPEAT, WIN_NOISE, WIN_LONE} t_window_kind;

    typedef struct {
        logic [WORD_W-1:0]   address;
        logic [WORD_W-1:0]   command;
        logic [STCODE_W-1:0] state;
        logic [BITCNT_W-1:0] bits;
    } t_frame;

    // clock and stimulus signals, all known from time zero
    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 edge_valid  = 1'b0;
    logic                 edge_ready;
    logic [TIME_W-1:0]    edge_data   = '0;
    logic                 edge_first  = 1'b0;
    logic                 edge_last   = 1'b0;
    logic                 frame_valid;
    logic                 frame_ready = 1'b1;
    logic [OUT_W-1:0]     frame_data;
    logic                 cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index   = '0;
    logic [LEN_W-1:0]     cfg_wdata   = '0;

    // decoder model state and its copy of the timing registers
    logic [LEN_W-1:0]     len_cfg [LEN_COUNT];
    logic [TOL_W-1:0]     tol_cfg;
    logic [TIME_W-1:0]    prev_time;
    logic [STCODE_W-1:0]  dec_state;
    logic [BITCNT_W-1:0]  bit_pos;
    logic [WORD_W-1:0]    addr_acc;
    logic [WORD_W-1:0]    cmd_acc;
    logic                 phase;
    logic                 idle_win;

    t_frame               pending_frames[$];
    logic [TIME_W-1:0]    span_q[$];

    bit gaps_on  = 1'b1;
    bit stall_on = 1'b1;
    int hold_ticket  = 0;
    int holds_served = 0;
    int errors       = 0;
    int edges_used   = 0;
    int frames_seen  = 0;
    int full_frames  = 0;
    int input_stalls = 0;
    int cycle_count  = 0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    nec_ir_edge_decoder_core DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (edge_valid),
        .o_s_axis_tready (edge_ready),
        .i_s_axis_tdata  (edge_data),    // [15:0] edge_time
        .i_s_axis_tuser  (edge_first),   // [0] first_edge
        .i_s_axis_tlast  (edge_last),
        .o_m_axis_tvalid (frame_valid),
        .i_m_axis_tready (frame_ready),
        .o_m_axis_tdata  (frame_data),   // [15:0] address, [31:16] command,
                                         // [34:32] final_state, [40:35] bit_count
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_wdata     (cfg_wdata)
    );

    // ------------------------------------------------------------------
    // Decoder model
    // ------------------------------------------------------------------

    // interval within tolerance of a nominal length, exact integer compare
    function automatic bit hit(input logic [TIME_W-1:0] d, input logic [LEN_W-1:0] len);
        int unsigned dev;
        dev = (int'(d) >= int'(len)) ? int'(d) - int'(len) : int'(len) - int'(d);
        return dev * 256 <= int'(len) * int'(tol_cfg);
    endfunction

    function automatic void post_frame();
        t_frame f;
        f.address = addr_acc;
        f.command = cmd_acc;
        f.state   = dec_state;
        f.bits    = bit_pos;
        idle_win  = 1'b1;
        if (dec_state == CODE_DONE) full_frames++;
        pending_frames.push_back(f);
    endfunction

    // one interval through the state machine; cases fall into the next one
    // when nothing matched. Returns 1 when the done case closes the window.
    function automatic bit advance_machine(input logic [TIME_W-1:0] d);
        logic [STCODE_W-1:0] s;
        s = dec_state;
        if (s == CODE_AGC) begin
            if (hit(d, len_cfg[REG_SPACER])) begin
                phase     = 1'b0;
                dec_state = CODE_SPACER;
                return 1'b0;
            end
            if (hit(d, len_cfg[REG_REPEAT])) begin
                dec_state = CODE_REPEAT;
                return 1'b0;
            end
            s = CODE_SPACER;
        end
        if (s == CODE_SPACER) begin
            if (hit(d, len_cfg[REG_BURST])) begin
                dec_state = CODE_CODE;
                bit_pos   = '0;
                addr_acc  = '0;
                cmd_acc   = '0;
                return 1'b0;
            end
            s = CODE_CODE;
        end
        if (s == CODE_CODE) begin
            // spaces carry data on even phase, bursts sit on odd phase
            if (!phase) begin
                if (hit(d, len_cfg[REG_ONE])) begin
                    if (bit_pos < BITS_PER_WORD) addr_acc[bit_pos[3:0]] = 1'b1;
                    else if (bit_pos < BITS_TOTAL) cmd_acc[bit_pos[3:0]] = 1'b1;
                    if (bit_pos < BITS_TOTAL) bit_pos++;
                    else dec_state = CODE_DONE;
                    return 1'b0;
                end
                if (hit(d, len_cfg[REG_ZERO])) begin
                    if (bit_pos < BITS_TOTAL) bit_pos++;
                    else dec_state = CODE_DONE;
                    return 1'b0;
                end
            end else if (hit(d, len_cfg[REG_BURST])) begin
                return 1'b0;
            end
            s = CODE_INVALID;
        end
        if (s == CODE_REPEAT) return 1'b0;
        if (s != CODE_DONE && bit_pos < BITS_TOTAL) begin
            dec_state = CODE_INVALID;
            return 1'b0;
        end
        dec_state = CODE_DONE;
        return 1'b1;
    endfunction

    // returns 1 when the edge was taken by the decoder, 0 when ignored
    function automatic bit decode_edge(input logic [TIME_W-1:0] stamp, input bit first,
                                       input bit last);
        logic [TIME_W-1:0] d;
        if (first) begin
            dec_state = CODE_INVALID;
            bit_pos   = '0;
            addr_acc  = '0;
            cmd_acc   = '0;
            phase     = 1'b0;
            idle_win  = 1'b0;
            prev_time = stamp;
            if (last) post_frame();
            return 1'b1;
        end
        if (idle_win) return 1'b0;
        d         = stamp - prev_time;   // wraps modulo 2^16
        phase     = ~phase;
        prev_time = stamp;
        if (advance_machine(d)) begin
            post_frame();
            return 1'b1;
        end
        if (hit(d, len_cfg[REG_AGC])) dec_state = CODE_AGC;
        if (last) post_frame();
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    function automatic void check_field(input string what, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk) begin : result_check
        t_frame want;
        if (rst_n && frame_valid && frame_ready) begin
            frames_seen++;
            if (pending_frames.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %0h", $time,
                         frame_data);
                errors++;
            end else begin
                want = pending_frames.pop_front();
                check_field("address", int'(want.address), int'(frame_data[15:0]));
                check_field("command", int'(want.command), int'(frame_data[31:16]));
                check_field("final_state", int'(want.state), int'(frame_data[34:32]));
                check_field("bit_count", int'(want.bits), int'(frame_data[40:35]));
                check_field("padding", 0, int'(frame_data[47:41]));
            end
        end
    end

    // run limit
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timed out after %0d cycles, %0d results outstanding", $time,
                     cycle_count, pending_frames.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Handshake drivers
    // ------------------------------------------------------------------

    // idle stretch: mostly short, now and then a long one
    function automatic int pause_len();
        if ($urandom_range(0, 9) == 0) return int'($urandom_range(12, 40));
        return int'($urandom_range(1, 3));
    endfunction

    // result side: random stalls, plus a long hold-off on request
    initial begin : result_sink
        int n;
        forever begin
            @(posedge clk);
            if (hold_ticket != holds_served) begin
                holds_served++;
                frame_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                frame_ready <= 1'b1;
            end else if (stall_on && $urandom_range(0, 3) == 0) begin
                n = pause_len();
                frame_ready <= 1'b0;
                repeat (n) @(posedge clk);
                frame_ready <= 1'b1;
            end else begin
                frame_ready <= 1'b1;
            end
        end
    end

    // one edge transaction; valid stays up afterwards unless a gap follows
    task automatic send_edge(input logic [TIME_W-1:0] stamp, input bit first, input bit last);
        int gap;
        gap = (gaps_on && $urandom_range(0, 2) == 0) ? pause_len() : 0;
        if (gap > 0) begin
            edge_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        edge_valid <= 1'b1;
        edge_data  <= stamp;
        edge_first <= first;
        edge_last  <= last;
        @(posedge clk);
        while (!edge_ready) begin
            input_stalls++;
            @(posedge clk);
        end
        if (decode_edge(stamp, first, last)) edges_used++;
    endtask

    // opener at start, then one edge per queued interval
    task automatic send_window(input logic [TIME_W-1:0] start, input int last_at);
        logic [TIME_W-1:0] t;
        int k;
        t = start;
        send_edge(t, 1'b1, last_at == 0);
        for (k = 0; k < span_q.size(); k++) begin
            t = t + span_q[k];
            send_edge(t, 1'b0, last_at == k + 1);
        end
    endtask

    // stop offering, let every expected result drain, then allow the pipe to empty
    task automatic settle();
        edge_valid <= 1'b0;
        while (pending_frames.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LEN_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        if (idx <= REG_ZERO) len_cfg[idx] = value;
        else if (idx == REG_TOL) tol_cfg = value[TOL_W-1:0];
    endtask

    // full register set; tolerance carries junk in its upper bits, plus a dead index
    task automatic program_timing(input int agc, input int spacer, input int rpt,
                                  input int burst, input int one, input int zero,
                                  input int tol);
        settle();
        write_reg(REG_AGC, LEN_W'(agc));
        write_reg(REG_SPACER, LEN_W'(spacer));
        write_reg(REG_REPEAT, LEN_W'(rpt));
        write_reg(REG_BURST, LEN_W'(burst));
        write_reg(REG_ONE, LEN_W'(one));
        write_reg(REG_ZERO, LEN_W'(zero));
        write_reg(REG_TOL, {6'($urandom), 8'(tol)});
        write_reg(REG_UNUSED, 14'($urandom));
        cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Random windows
    // ------------------------------------------------------------------

    // interval near a nominal length; rarely on or just past the tolerance edge,
    // rarely pure noise
    function automatic logic [TIME_W-1:0] near(input logic [LEN_W-1:0] len);
        int slack;
        int r;
        slack = (int'(len) * int'(tol_cfg)) >> 8;
        r = $urandom_range(0, 255);
        if (r == 0) return 16'($urandom);
        if (r == 1) return 16'(int'(len) + slack + 1);
        if (r == 2 && int'(len) > slack) return 16'(int'(len) - slack - 1);
        if (r == 3) return 16'(int'(len) + slack);
        if (r == 4) return 16'(int'(len) - slack);
        return 16'(int'(len) - slack + int'($urandom_range(0, 2 * slack)));
    endfunction

    task automatic run_windows(input int budget);
        int stop_at;
        int last_at;
        int k;
        int n;
        int r;
        t_window_kind kind;
        stop_at = edges_used + budget;
        while (edges_used < stop_at) begin
            // switch idling on and off in stretches
            if ($urandom_range(0, 7) == 0) begin
                gaps_on  = $urandom_range(0, 2) != 0;
                stall_on <= $urandom_range(0, 2) != 0;
            end
            r = $urandom_range(0, 99);
            kind = (r < 35) ? WIN_FRAME : (r < 55) ? WIN_REPEAT : (r < 85) ? WIN_NOISE
                 : WIN_LONE;
            span_q.delete();
            case (kind)
                WIN_FRAME: begin
                    span_q.push_back(near(len_cfg[REG_AGC]));
                    span_q.push_back(near(len_cfg[REG_SPACER]));
                    span_q.push_back(near(len_cfg[REG_BURST]));
                    // 32 data bits, then one spare space to reach done, then anything
                    for (k = 0; k <= 32; k++) begin
                        span_q.push_back(near($urandom_range(0, 1) ? len_cfg[REG_ONE]
                                                                   : len_cfg[REG_ZERO]));
                        if (k < 32) span_q.push_back(near(len_cfg[REG_BURST]));
                    end
                    span_q.push_back(16'($urandom));
                end
                WIN_REPEAT: begin
                    span_q.push_back(near(len_cfg[REG_AGC]));
                    span_q.push_back(near(len_cfg[REG_REPEAT]));
                    span_q.push_back(near(len_cfg[REG_BURST]));
                    n = $urandom_range(0, 3);
                    for (k = 0; k < n; k++)
                        span_q.push_back(near($urandom_range(0, 1) ? len_cfg[REG_BURST]
                                                                   : len_cfg[REG_AGC]));
                end
                WIN_NOISE: begin
                    n = $urandom_range(1, 10);
                    for (k = 0; k < n; k++) begin
                        r = $urandom_range(0, 7);
                        if (r == 0) span_q.push_back('0);
                        else if (r == 1) span_q.push_back(16'($urandom));
                        else span_q.push_back(near(len_cfg[$urandom_range(0, LEN_COUNT - 1)]));
                    end
                end
                default: ;
            endcase
            // where the window is closed: never, early, or on its final edge
            r = $urandom_range(0, 3);
            if (kind == WIN_LONE) last_at = (r == 0) ? -1 : 0;
            else if (r == 0) last_at = -1;
            else if (r == 1) last_at = $urandom_range(1, span_q.size());
            else last_at = span_q.size();
            send_window(16'($urandom), last_at);
            if ($urandom_range(0, 5) == 0)
                send_edge(16'($urandom), 1'b0, 1'($urandom_range(0, 1)));
        end
        // leave no window open across a register update
        send_edge(16'($urandom), 1'b1, 1'b1);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // stray edges, and windows of a single edge at the timestamp extremes
    task automatic test_lone_edges();
        send_edge(16'h1234, 1'b0, 1'b0);
        send_edge(16'hFFFF, 1'b1, 1'b1);
        send_edge(16'h0000, 1'b1, 1'b1);
        send_edge(16'h5555, 1'b0, 1'b1);
    endtask

    // repeat code whose AGC interval wraps the timestamp; trailing edge is dropped
    task automatic test_repeat_code();
        span_q = '{16'd9000, 16'd2250, 16'd562, 16'd562};
        send_window(16'hF000, 3);
    endtask

    // window abandoned by a new opener, no result for the first one
    task automatic test_reopen();
        span_q = '{16'd9000};
        send_window(16'h0100, -1);
        span_q = '{16'd9000, 16'd4500};
        send_window(16'hAAAA, 2);
    endtask

    // one data bit, then a space that matches nothing, closed by tlast
    task automatic test_broken_frame();
        span_q = '{16'd9000, 16'd4500, 16'd562, 16'd1687, 16'd562, 16'd3000, 16'd562};
        send_window(16'h7FFF, 7);
    endtask

    // long result hold-off while openers keep coming, so the input backs up
    task automatic test_backpressure();
        int k;
        settle();
        gaps_on  = 1'b0;
        stall_on <= 1'b0;
        hold_ticket <= hold_ticket + 1;
        for (k = 0; k < 24; k++) send_edge(16'($urandom), 1'b1, 1'b1);
        gaps_on  = 1'b1;
        stall_on <= 1'b1;
        settle();
    endtask

    task automatic test_default_timing();
        run_windows(450);
    endtask

    // proportional timing built on a random unit length
    task automatic test_scaled_timing();
        int u;
        int pass;
        for (pass = 0; pass < 2; pass++) begin
            u = $urandom_range(1, 1023);
            program_timing(16 * u, 8 * u, 4 * u, u, 3 * u, u, $urandom_range(0, 96));
            run_windows(250);
        end
    endtask

    task automatic test_exact_tolerance();
        program_timing(int'(RST_LEN[REG_AGC]), int'(RST_LEN[REG_SPACER]),
                       int'(RST_LEN[REG_REPEAT]), int'(RST_LEN[REG_BURST]),
                       int'(RST_LEN[REG_ONE]), int'(RST_LEN[REG_ZERO]), 0);
        run_windows(150);
    endtask

    task automatic test_widest_lengths();
        program_timing(16383, 16383, 16383, 16383, 16383, 16383, 255);
        run_windows(120);
    endtask

    task automatic test_zero_lengths();
        program_timing(0, 0, 0, 0, 0, 0, $urandom_range(0, 255));
        run_windows(80);
    endtask

    task automatic test_restored_defaults();
        program_timing(int'(RST_LEN[REG_AGC]), int'(RST_LEN[REG_SPACER]),
                       int'(RST_LEN[REG_REPEAT]), int'(RST_LEN[REG_BURST]),
                       int'(RST_LEN[REG_ONE]), int'(RST_LEN[REG_ZERO]), int'(RST_TOL));
        run_windows(100);
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        len_cfg   = RST_LEN;
        tol_cfg   = RST_TOL;
        prev_time = '0;
        dec_state = CODE_INVALID;
        bit_pos   = '0;
        addr_acc  = '0;
        cmd_acc   = '0;
        phase     = 1'b0;
        idle_win  = 1'b1;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        test_lone_edges();
        test_repeat_code();
        test_reopen();
        test_broken_frame();
        test_backpressure();
        test_default_timing();
        test_scaled_timing();
        test_exact_tolerance();
        test_widest_lengths();
        test_zero_lengths();
        test_restored_defaults();
        settle();

        $display("Decoded %0d edges into %0d results, %0d of them frames that reached done.",
                 edges_used, frames_seen, full_frames);
        $display("Edge input was held off for %0d cycles; %0d mismatches.", input_stalls,
                 errors);
        if (errors == 0) $display("[ OK ] regression clean");
        else $display("[FAIL] regression broken");
        $finish;
    end

endmodule
